@@ rtl/tsdq_pkg.sv @@
// Shared widths and command codes for the two-stack deque unit.
// Depends on nothing; used by tsdq_stack_ram and two_stack_deque_unit.
package tsdq_pkg;

    // Fixed field widths of the command and result transactions.
    localparam int VALUE_W = 32;
    localparam int CMD_W   = 3;
    localparam int POS_W   = 6;
    localparam int LEN_W   = 7;

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
    localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_SEARCH     = 3'd4;

endpackage

@@ rtl/two_stack_deque_unit.sv @@
// Two-stack deque: a front and a back stack held in two synchronous RAMs.
// Depends on tsdq_pkg and tsdq_stack_ram.
//
// A command transaction is taken at a clock edge with start high and busy low.
// Push, pop and unused codes finish at once: the result strobe o_valid is
// high in the next cycle and busy stays low, so such commands can follow each
// other every cycle. A search reads one stored element per cycle through the
// RAM read port, the front stack from its bottom and then the back stack, and
// raises busy while it runs. Each element is compared with the key once its
// registered read data arrives; the first match ends the search, and a search
// without a match ends after the last element, or at once with both stacks empty.
// Each result is presented for exactly one cycle and cannot be held off.
module two_stack_deque_unit #(
    parameter int STACK_DEPTH = 32
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic [tsdq_pkg::CMD_W-1:0]           i_cmd,
    input  logic signed [tsdq_pkg::VALUE_W-1:0]  i_value,
    output logic                                 o_valid,
    output logic                                 o_found,
    output logic [tsdq_pkg::POS_W-1:0]           o_position,
    output logic                                 o_is_empty,
    output logic [tsdq_pkg::LEN_W-1:0]           o_total_length
);

    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(STACK_DEPTH);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_SCAN = 1'b1;

    // Control registers.
    logic          r_state, n_state;
    logic [CW-1:0] r_front_count, n_front_count;
    logic [CW-1:0] r_back_count, n_back_count;
    logic          r_active, n_active;
    logic          r_phase, n_phase;
    logic [AW-1:0] r_idx, n_idx;
    logic          r_chk_valid, n_chk_valid;
    logic          r_valid, n_valid;

    // Payload registers.
    logic [tsdq_pkg::VALUE_W-1:0] r_key, n_key;
    logic                         r_chk_phase, n_chk_phase;
    logic [CW-1:0]                r_chk_pos, n_chk_pos;
    logic                         r_found, n_found;
    logic [tsdq_pkg::POS_W-1:0]   r_position, n_position;
    logic                         r_is_empty, n_is_empty;
    logic [tsdq_pkg::LEN_W-1:0]   r_total, n_total;

    // RAM ports.
    logic                         front_we;
    logic                         back_we;
    logic [tsdq_pkg::VALUE_W-1:0] front_rdata;
    logic [tsdq_pkg::VALUE_W-1:0] back_rdata;
    logic [tsdq_pkg::VALUE_W-1:0] chk_data;

    // Helpers for field width conversion.
    logic [CW:0]   len_sum;
    logic [31:0]   len_wide;
    logic [31:0]   pos_wide;
    logic [CW-1:0] idx_next;

    tsdq_stack_ram #(
        .DEPTH (STACK_DEPTH),
        .AW    (AW)
    ) u_front_ram (
        .i_clk   (i_clk),
        .i_we    (front_we),
        .i_waddr (r_front_count[AW-1:0]),
        .i_wdata ($unsigned(i_value)),
        .i_raddr (r_idx),
        .o_rdata (front_rdata)
    );

    tsdq_stack_ram #(
        .DEPTH (STACK_DEPTH),
        .AW    (AW)
    ) u_back_ram (
        .i_clk   (i_clk),
        .i_we    (back_we),
        .i_waddr (r_back_count[AW-1:0]),
        .i_wdata ($unsigned(i_value)),
        .i_raddr (r_idx),
        .o_rdata (back_rdata)
    );

    assign chk_data = r_chk_phase ? back_rdata : front_rdata;
    assign idx_next = CW'(r_idx) + CW'(1);
    assign pos_wide = 32'(r_chk_pos);

    // Command decode, search sequencing and result formation.
    always_comb begin
        n_state       = r_state;
        n_front_count = r_front_count;
        n_back_count  = r_back_count;
        n_active      = r_active;
        n_phase       = r_phase;
        n_idx         = r_idx;
        n_chk_valid   = r_chk_valid;
        n_chk_phase   = r_chk_phase;
        n_chk_pos     = r_chk_pos;
        n_key         = r_key;
        n_valid       = 1'b0;
        n_found       = 1'b0;
        n_position    = '0;
        front_we      = 1'b0;
        back_we       = 1'b0;

        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_valid = 1'b1;
                    case (i_cmd)
                        tsdq_pkg::CMD_PUSH_FRONT: begin
                            if (r_front_count != DEPTH_C) begin
                                front_we      = 1'b1;
                                n_front_count = r_front_count + CW'(1);
                            end
                        end
                        tsdq_pkg::CMD_PUSH_BACK: begin
                            if (r_back_count != DEPTH_C) begin
                                back_we      = 1'b1;
                                n_back_count = r_back_count + CW'(1);
                            end
                        end
                        tsdq_pkg::CMD_POP_FRONT: begin
                            if (r_front_count != '0) begin
                                n_front_count = r_front_count - CW'(1);
                            end
                        end
                        tsdq_pkg::CMD_POP_BACK: begin
                            if (r_back_count != '0) begin
                                n_back_count = r_back_count - CW'(1);
                            end
                        end
                        tsdq_pkg::CMD_SEARCH: begin
                            // Start the scan at the bottom of the first non-empty stack.
                            n_valid     = 1'b0;
                            n_state     = ST_SCAN;
                            n_key       = $unsigned(i_value);
                            n_idx       = '0;
                            n_phase     = (r_front_count == '0);
                            n_active    = (r_front_count != '0) || (r_back_count != '0);
                            n_chk_valid = 1'b0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                // Issue one read per cycle and step through front, then back.
                n_chk_valid = r_active;
                n_chk_phase = r_phase;
                n_chk_pos   = idx_next;
                if (r_active) begin
                    if (!r_phase) begin
                        if (idx_next < r_front_count) begin
                            n_idx = idx_next[AW-1:0];
                        end else begin
                            n_idx    = '0;
                            n_phase  = 1'b1;
                            n_active = (r_back_count != '0);
                        end
                    end else begin
                        if (idx_next < r_back_count) begin
                            n_idx = idx_next[AW-1:0];
                        end else begin
                            n_active = 1'b0;
                        end
                    end
                end

                // Compare the element read in the previous cycle.
                if (r_chk_valid && (chk_data == r_key)) begin
                    n_valid    = 1'b1;
                    n_found    = 1'b1;
                    n_position = pos_wide[tsdq_pkg::POS_W-1:0];
                    n_state    = ST_IDLE;
                    n_active   = 1'b0;
                end else if (!r_active && !r_chk_valid) begin
                    n_valid = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // Length and emptiness after the step.
        len_sum    = {1'b0, n_front_count} + {1'b0, n_back_count};
        len_wide   = 32'(len_sum);
        n_total    = len_wide[tsdq_pkg::LEN_W-1:0];
        n_is_empty = (len_sum == '0);
    end

    // Control state with synchronous reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_front_count <= '0;
            r_back_count  <= '0;
            r_active      <= 1'b0;
            r_phase       <= 1'b0;
            r_idx         <= '0;
            r_chk_valid   <= 1'b0;
            r_valid       <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_front_count <= n_front_count;
            r_back_count  <= n_back_count;
            r_active      <= n_active;
            r_phase       <= n_phase;
            r_idx         <= n_idx;
            r_chk_valid   <= n_chk_valid;
            r_valid       <= n_valid;
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge i_clk) begin
        r_key       <= n_key;
        r_chk_phase <= n_chk_phase;
        r_chk_pos   <= n_chk_pos;
        r_found     <= n_found;
        r_position  <= n_position;
        r_is_empty  <= n_is_empty;
        r_total     <= n_total;
    end

    assign busy           = (r_state != ST_IDLE);
    assign o_valid        = r_valid;
    assign o_found        = r_found;
    assign o_position     = r_position;
    assign o_is_empty     = r_is_empty;
    assign o_total_length = r_total;

endmodule

@@ rtl/tsdq_stack_ram.sv @@
// Element storage of one stack: one write port and one registered read port.
// Depends on tsdq_pkg for the element width.
module tsdq_stack_ram #(
    parameter int DEPTH = 32,
    parameter int AW    = 5
) (
    input  logic                          i_clk,
    input  logic                          i_we,
    input  logic [AW-1:0]                 i_waddr,
    input  logic [tsdq_pkg::VALUE_W-1:0]  i_wdata,
    input  logic [AW-1:0]                 i_raddr,
    output logic [tsdq_pkg::VALUE_W-1:0]  o_rdata
);

    logic [tsdq_pkg::VALUE_W-1:0] r_mem [DEPTH];
    logic [tsdq_pkg::VALUE_W-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port with registered read data.
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
